@@ sv/serial_command_line_parser_assert.svh @@
// Assertion macros for the serial command line parser.
// An immediate implication and a next-cycle implication, both disabled in reset.
`ifndef SERIAL_COMMAND_LINE_PARSER_ASSERT_SVH
`define SERIAL_COMMAND_LINE_PARSER_ASSERT_SVH

`ifndef SYNTH
`define SCLP_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed in serial command line parser");
`define SCLP_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed in serial command line parser");
`else
`define SCLP_ASSERT_NOW(label, clk, rst, cond, prop)
`define SCLP_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif

`endif

@@ sv/sclp_pkg.sv @@
`timescale 1ns / 1ps

package sclp_pkg;

   // Characters that the parser recognizes.
   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_SPACE   = 8'd32;
   localparam logic [7:0] CH_PLUS    = 8'd43;
   localparam logic [7:0] CH_MINUS   = 8'd45;
   localparam logic [7:0] CH_ZERO    = 8'd48;
   localparam logic [7:0] CH_NINE    = 8'd57;
   localparam logic [7:0] CH_M       = 8'd77;
   localparam logic [7:0] CH_G       = 8'd71;
   localparam logic [7:0] CH_H       = 8'd72;
   localparam logic [7:0] CH_F       = 8'd70;

   // Event kinds.
   localparam logic [2:0] KIND_MOVE    = 3'd0;
   localparam logic [2:0] KIND_GUN     = 3'd1;
   localparam logic [2:0] KIND_HORN    = 3'd2;
   localparam logic [2:0] KIND_FIRE    = 3'd3;
   localparam logic [2:0] KIND_UNKNOWN = 3'd4;

   // Number of numeric fields on a line; a field index of this value means past the end.
   localparam int unsigned FIELD_COUNT = 3;
   localparam logic [1:0]  FIELD_PAST  = 2'd3;

   // Position within the line.
   typedef enum logic [2:0] {
      POS_LETTER = 3'b001,
      POS_SKIP   = 3'b010,
      POS_FIELDS = 3'b100
   } pos_type;

endpackage

@@ sv/serial_command_line_parser.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Ports                                         Meaning
// req       in         req_valid, req_stall, req_rx_byte             one received character
// rsp       out        rsp_valid, rsp_stall, rsp_event_kind,         one event per line
//                      rsp_param_one, rsp_param_two, rsp_param_three
//
// Each character is parsed in the cycle it is accepted; one character per cycle while the request is not stalled.
// A line's event appears in the output register in the cycle after its newline is accepted.
// Reset is synchronous and active high; it clears the line state and the output valid flag, not the payload.
// A request is stalled only while a finished event is held and the result side stalls.

`include "serial_command_line_parser_assert.svh"

module serial_command_line_parser
   import sclp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_event_kind,
   output logic [7:0] rsp_param_one,
   output logic [7:0] rsp_param_two,
   output logic [7:0] rsp_param_three
);

   // Line state.
   pos_type    pos_ff, pos_in;
   logic [2:0] cmd_ff, cmd_in;
   logic [1:0] field_num_ff, field_num_in;
   logic [7:0] field_ff [FIELD_COUNT];
   logic [7:0] field_in [FIELD_COUNT];
   logic       neg_ff, neg_in;
   logic       sign_ok_ff, sign_ok_in;
   logic       ended_ff, ended_in;

   // Output register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] kind_ff, kind_in;
   logic [7:0] p1_ff, p1_in;
   logic [7:0] p2_ff, p2_in;
   logic [7:0] p3_ff, p3_in;

   logic       accept;
   logic       is_newline;
   logic       in_field;
   logic [7:0] cur_value;
   logic [7:0] digit_value;
   logic [7:0] closed [FIELD_COUNT];

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign accept     = req_valid && !req_stall;
   assign is_newline = (req_rx_byte == CH_NEWLINE);
   assign in_field   = (field_num_ff != FIELD_PAST);

   // Current number and its next value after a digit: value * 10 + digit, modulo 256.
   assign cur_value   = in_field ? field_ff[field_num_ff] : 8'd0;
   assign digit_value = 8'({cur_value, 3'b000} + {cur_value, 1'b0} + (req_rx_byte - CH_ZERO));

   // Field values with the pending sign applied to the current number.
   always_comb begin
      for (int i = 0; i < FIELD_COUNT; i++) begin
         if (neg_ff && field_num_ff == 2'(i)) begin
            closed[i] = 8'(~field_ff[i] + 8'd1);
         end else begin
            closed[i] = field_ff[i];
         end
      end
   end

   // Next line state for the accepted character.
   always_comb begin
      pos_in       = pos_ff;
      cmd_in       = cmd_ff;
      field_num_in = field_num_ff;
      neg_in       = neg_ff;
      sign_ok_in   = sign_ok_ff;
      ended_in     = ended_ff;
      for (int i = 0; i < FIELD_COUNT; i++) begin
         field_in[i] = field_ff[i];
      end

      if (accept) begin
         if (is_newline) begin
            pos_in       = POS_LETTER;
            cmd_in       = KIND_UNKNOWN;
            field_num_in = 2'd0;
            neg_in       = 1'b0;
            sign_ok_in   = 1'b1;
            ended_in     = 1'b0;
            for (int i = 0; i < FIELD_COUNT; i++) begin
               field_in[i] = 8'd0;
            end
         end else begin
            case (pos_ff)
               POS_LETTER: begin
                  case (req_rx_byte)
                     CH_M:    cmd_in = KIND_MOVE;
                     CH_G:    cmd_in = KIND_GUN;
                     CH_H:    cmd_in = KIND_HORN;
                     CH_F:    cmd_in = KIND_FIRE;
                     default: cmd_in = KIND_UNKNOWN;
                  endcase
                  pos_in = POS_SKIP;
               end
               POS_SKIP: begin
                  pos_in = POS_FIELDS;
               end
               POS_FIELDS: begin
                  if (req_rx_byte == CH_SPACE) begin
                     // A space closes the number and moves to the next field.
                     for (int i = 0; i < FIELD_COUNT; i++) begin
                        field_in[i] = closed[i];
                     end
                     neg_in     = 1'b0;
                     sign_ok_in = 1'b1;
                     ended_in   = 1'b0;
                     if (in_field) begin
                        field_num_in = field_num_ff + 2'd1;
                     end
                  end else if (in_field) begin
                     if (sign_ok_ff && (req_rx_byte == CH_PLUS || req_rx_byte == CH_MINUS)) begin
                        neg_in     = (req_rx_byte == CH_MINUS);
                        sign_ok_in = 1'b0;
                     end else if (req_rx_byte inside {[CH_ZERO:CH_NINE]} && !ended_ff) begin
                        field_in[field_num_ff] = digit_value;
                        sign_ok_in             = 1'b0;
                     end else begin
                        // Any other character ends the number.
                        ended_in   = 1'b1;
                        sign_ok_in = 1'b0;
                     end
                  end
               end
               default: begin
                  pos_in = POS_LETTER;
               end
            endcase
         end
      end
   end

   // Output register: loaded on a newline, emptied when the event is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      p3_in        = p3_ff;
      if (accept && is_newline) begin
         rsp_valid_in = 1'b1;
         kind_in      = cmd_ff;
         p1_in        = (cmd_ff == KIND_MOVE || cmd_ff == KIND_GUN) ? closed[0] : 8'd0;
         p2_in        = (cmd_ff == KIND_MOVE || cmd_ff == KIND_GUN) ? closed[1] : 8'd0;
         p3_in        = (cmd_ff == KIND_MOVE) ? closed[2] : 8'd0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_LETTER;
         cmd_ff       <= KIND_UNKNOWN;
         field_num_ff <= 2'd0;
         neg_ff       <= 1'b0;
         sign_ok_ff   <= 1'b1;
         ended_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < FIELD_COUNT; i++) begin
            field_ff[i] <= 8'd0;
         end
      end else begin
         pos_ff       <= pos_in;
         cmd_ff       <= cmd_in;
         field_num_ff <= field_num_in;
         neg_ff       <= neg_in;
         sign_ok_ff   <= sign_ok_in;
         ended_ff     <= ended_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < FIELD_COUNT; i++) begin
            field_ff[i] <= field_in[i];
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      p3_ff   <= p3_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = kind_ff;
   assign rsp_param_one   = p1_ff;
   assign rsp_param_two   = p2_ff;
   assign rsp_param_three = p3_ff;

   // A newline always produces an event in the next cycle.
   `SCLP_ASSERT_NEXT(a_newline_event, clock, reset, accept && is_newline, rsp_valid_ff)
   // A newline returns the parser to the start of a line.
   `SCLP_ASSERT_NEXT(a_newline_clears, clock, reset, accept && is_newline,
      pos_ff == POS_LETTER && cmd_ff == KIND_UNKNOWN && field_num_ff == 2'd0)
   // Fields are only counted once past the command letter and the skipped character.
   `SCLP_ASSERT_NOW(a_fields_after_header, clock, reset, pos_ff != POS_FIELDS,
      field_num_ff == 2'd0 && !neg_ff && !ended_ff)
   // Commands without two numbers report zero parameters.
   `SCLP_ASSERT_NOW(a_unused_params_zero, clock, reset,
      rsp_valid_ff && kind_ff != KIND_MOVE && kind_ff != KIND_GUN,
      p1_ff == 8'd0 && p2_ff == 8'd0 && p3_ff == 8'd0)
   // Only a move carries a third parameter.
   `SCLP_ASSERT_NOW(a_third_param_move, clock, reset,
      rsp_valid_ff && kind_ff != KIND_MOVE, p3_ff == 8'd0)

endmodule
